// ===== sv/shadow_bitmap_access_checker_macros.svh =====
// Assertion helpers for the shadow bitmap checker
`ifndef SHADOW_BITMAP_ACCESS_CHECKER_MACROS_SVH
`define SHADOW_BITMAP_ACCESS_CHECKER_MACROS_SVH
`define SBAC_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define SBAC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== sv/sbac_pkg.sv =====
package sbac_pkg;
  localparam int SHADOW_BYTES = 8192;
  localparam int ALLOC_SLOTS = 32;
  localparam int SH_AW = $clog2(SHADOW_BYTES);
  localparam int SL_AW = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
  localparam int SL_CW = $clog2(ALLOC_SLOTS + 1);
  localparam logic [16:0] SIZE_LIMIT = 17'h10000;
  localparam logic [7:0] FULL_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    REQ_LOAD = 3'd0, REQ_STORE = 3'd1, REQ_UNPOISON = 3'd2,
    REQ_POISON = 3'd3, REQ_ALLOC = 3'd4, REQ_FREE = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_UNMON = 2'd1, ST_FULL = 2'd2, ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0, REG_BASE = 2'd1, REG_END = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WIN, S_SCAN_RD, S_SCAN_CHK, S_SPAN,
    S_SH_RD, S_SH_WAIT, S_SH_WR, S_DONE
  } state_t;

  // byte mask from bit lo to bit hi inclusive
  function automatic logic [7:0] span_mask(logic [2:0] lo, logic [2:0] hi);
    logic [7:0] m;
    m = (FULL_BYTE >> (3'd7 - (hi - lo))) << lo;
    return m;
  endfunction
endpackage

// ===== sv/sbac_ram.sv =====
module sbac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/shadow_bitmap_access_checker.sv =====
// Channel  | Ports                                   | Handshake
// request  | in_req_type, in_address, in_region_size | start & !busy
// result   | out_access_ok, out_status, out_store_op, | out_valid, one cycle
//          | out_fault_address, out_fault_size       |
// config   | psel/penable/pwrite/paddr/pwdata/prdata | APB, pready tied high
// After reset a clearing pass zeroes the shadow memory, one byte per cycle,
// with busy high; config writes still work then.
// A request goes from S_IDLE to S_DONE, straight when it is ignored; else
// alloc/free scan the slots (S_SCAN_RD, S_SCAN_CHK), then S_WIN and a loop over
// the shadow bytes (S_SH_RD, S_SH_WAIT, S_SH_WR); a check stops at the first poisoned byte.
// The result strobe lasts one cycle; the receiver cannot stall it.
module shadow_bitmap_access_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_address,
  input  logic [16:0] in_region_size,
  output logic        out_valid,
  output logic        out_access_ok,
  output logic [1:0]  out_status,
  output logic        out_store_op,
  output logic [31:0] out_fault_address,
  output logic [16:0] out_fault_size,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SH_AW = sbac_pkg::SH_AW;
  localparam int SL_AW = sbac_pkg::SL_AW;
  localparam int SL_CW = sbac_pkg::SL_CW;

  sbac_pkg::state_t state_r, state_nxt;
  logic        en_r;
  logic [31:0] base_r, end_r;
  logic [2:0]  typ_r;
  logic [31:0] addr_r;
  logic [16:0] size_r, size_nxt, span_r, span_nxt;
  logic [SH_AW:0] clr_r, clr_nxt;
  logic [SL_CW-1:0] k_r, k_nxt;
  logic [SL_AW-1:0] slot_r, slot_nxt;
  logic        ok_r, ok_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [32:0] rel_r, rel_nxt;
  logic [32:0] lastb_r, lastb_nxt;
  logic [32:0] idx_r, idx_nxt;
  logic        pois_r, pois_nxt;

  // slot memory: {address, size}
  logic        sl_we;
  logic [SL_AW-1:0] sl_waddr, sl_raddr;
  logic [48:0] sl_wdata, sl_rdata;
  logic        sh_we;
  logic [SH_AW-1:0] sh_waddr, sh_raddr;
  logic [7:0]  sh_wdata, sh_rdata, sh_m;

  sbac_ram #(.WIDTH(49), .DEPTH(sbac_pkg::ALLOC_SLOTS)) u_slots (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rdata));
  sbac_ram #(.WIDTH(8), .DEPTH(sbac_pkg::SHADOW_BYTES)) u_shadow (
    .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
    .raddr(sh_raddr), .rdata(sh_rdata));

  // slot valid bits, held in flops beside the slot memory
  logic [sbac_pkg::ALLOC_SLOTS-1:0] sv_r, sv_nxt;

  assign pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      sbac_pkg::REG_ENABLE: prdata = {31'd0, en_r};
      sbac_pkg::REG_BASE:   prdata = base_r;
      sbac_pkg::REG_END:    prdata = end_r;
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
      base_r <= 32'd0;
      end_r <= 32'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sbac_pkg::REG_ENABLE: en_r <= pwdata[0];
        sbac_pkg::REG_BASE:   base_r <= pwdata;
        sbac_pkg::REG_END:    end_r <= pwdata;
        default: ;
      endcase
    end
  end

  logic [32:0] e_sum, rel_c, last_c;
  logic        mon_c;
  logic [SL_AW-1:0] k_idx;
  logic [31:0] sl_addr_q;
  logic        sl_valid_q;
  assign k_idx = k_r[SL_AW-1:0];
  assign sl_addr_q = sl_rdata[48:17];
  assign sl_valid_q = sv_r[slot_r];

  always_comb begin
    e_sum  = {1'b0, addr_r} + {16'd0, span_r};
    rel_c  = {1'b0, addr_r} - {1'b0, base_r};
    last_c = rel_c + {16'd0, span_r} - 33'd1;
    mon_c  = (span_r <= sbac_pkg::SIZE_LIMIT) && (addr_r >= base_r)
             && (e_sum <= {1'b0, end_r})
             && ((span_r == 17'd0) || ((last_c >> 3) < 33'(sbac_pkg::SHADOW_BYTES)));
  end

  always_comb begin
    logic [2:0] lo, hi;
    lo = (idx_r == (rel_r >> 3)) ? rel_r[2:0] : 3'd0;
    hi = (idx_r == (lastb_r >> 3)) ? lastb_r[2:0] : 3'd7;
    sh_m = sbac_pkg::span_mask(lo, hi);
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    k_nxt = k_r; slot_nxt = slot_r;
    ok_nxt = ok_r; st_nxt = st_r; rel_nxt = rel_r; lastb_nxt = lastb_r;
    idx_nxt = idx_r; pois_nxt = pois_r; size_nxt = size_r; span_nxt = span_r;
    sv_nxt = sv_r;
    sl_we = 1'b0; sl_waddr = slot_r; sl_wdata = {addr_r, span_r};
    sl_raddr = k_idx;
    sh_we = 1'b0; sh_waddr = idx_r[SH_AW-1:0]; sh_wdata = 8'd0;
    sh_raddr = idx_r[SH_AW-1:0];
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      sbac_pkg::S_CLEAR: begin
        sh_we = 1'b1;
        sh_waddr = clr_r[SH_AW-1:0];
        sh_wdata = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (SH_AW+1)'(sbac_pkg::SHADOW_BYTES - 1)) state_nxt = sbac_pkg::S_IDLE;
      end
      sbac_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          size_nxt = in_region_size;
          span_nxt = in_region_size;
          ok_nxt = 1'b1; st_nxt = sbac_pkg::ST_DONE;
          k_nxt = '0;
          pois_nxt = (in_req_type == sbac_pkg::REQ_POISON);
          case (in_req_type)
            sbac_pkg::REQ_LOAD, sbac_pkg::REQ_STORE,
            sbac_pkg::REQ_UNPOISON, sbac_pkg::REQ_POISON: state_nxt = sbac_pkg::S_WIN;
            sbac_pkg::REQ_ALLOC, sbac_pkg::REQ_FREE:
              state_nxt = (in_address == 32'd0) ? sbac_pkg::S_DONE : sbac_pkg::S_SCAN_RD;
            default: state_nxt = sbac_pkg::S_DONE;
          endcase
        end
      end
      sbac_pkg::S_SCAN_RD: begin
        // free: read slot k; alloc uses valid bits only
        sl_raddr = k_idx;
        slot_nxt = k_idx;
        state_nxt = sbac_pkg::S_SCAN_CHK;
      end
      sbac_pkg::S_SCAN_CHK: begin
        if (typ_r == sbac_pkg::REQ_ALLOC ? !sl_valid_q
            : (sl_valid_q && sl_addr_q == addr_r)) begin
          if (typ_r == sbac_pkg::REQ_FREE) begin
            span_nxt = sl_rdata[16:0];
            pois_nxt = 1'b1;
            sv_nxt[slot_r] = 1'b0;
          end else begin
            sl_we = 1'b1;
            sv_nxt[slot_r] = 1'b1;
          end
          state_nxt = sbac_pkg::S_WIN;
        end else if (k_r == SL_CW'(sbac_pkg::ALLOC_SLOTS - 1)) begin
          st_nxt = (typ_r == sbac_pkg::REQ_ALLOC) ? sbac_pkg::ST_FULL : sbac_pkg::ST_NOTFOUND;
          state_nxt = sbac_pkg::S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = sbac_pkg::S_SCAN_RD;
        end
      end
      sbac_pkg::S_WIN: begin
        rel_nxt = rel_c;
        lastb_nxt = last_c;
        idx_nxt = rel_c >> 3;
        if (typ_r == sbac_pkg::REQ_LOAD || typ_r == sbac_pkg::REQ_STORE) begin
          if (!en_r) state_nxt = sbac_pkg::S_DONE;
          else if (!mon_c) begin
            st_nxt = sbac_pkg::ST_UNMON; state_nxt = sbac_pkg::S_DONE;
          end else if (span_r == 17'd0) state_nxt = sbac_pkg::S_DONE;
          else state_nxt = sbac_pkg::S_SH_RD;
        end else if (!mon_c) begin
          st_nxt = sbac_pkg::ST_UNMON; state_nxt = sbac_pkg::S_DONE;
        end else if (span_r == 17'd0) state_nxt = sbac_pkg::S_DONE;
        else state_nxt = sbac_pkg::S_SH_RD;
      end
      sbac_pkg::S_SH_RD: state_nxt = sbac_pkg::S_SH_WAIT;
      sbac_pkg::S_SH_WAIT: state_nxt = sbac_pkg::S_SH_WR;
      sbac_pkg::S_SH_WR: begin
        if (typ_r == sbac_pkg::REQ_LOAD || typ_r == sbac_pkg::REQ_STORE) begin
          if ((sh_rdata & sh_m) != 8'd0) ok_nxt = 1'b0;
        end else begin
          sh_we = 1'b1;
          sh_wdata = pois_r ? (sh_rdata | sh_m) : (sh_rdata & ~sh_m);
        end
        if (idx_r == (lastb_r >> 3) || ok_nxt == 1'b0) state_nxt = sbac_pkg::S_DONE;
        else begin
          idx_nxt = idx_r + 33'd1;
          state_nxt = sbac_pkg::S_SH_RD;
        end
      end
      sbac_pkg::S_DONE: begin
        out_valid = 1'b1;
        state_nxt = sbac_pkg::S_IDLE;
      end
      default: state_nxt = sbac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbac_pkg::S_CLEAR;
      clr_r <= '0;
      sv_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sbac_pkg::S_IDLE && start) begin
      typ_r <= in_req_type;
      addr_r <= in_address;
    end
    k_r <= k_nxt; slot_r <= slot_nxt;
    ok_r <= ok_nxt; st_r <= st_nxt; rel_r <= rel_nxt; lastb_r <= lastb_nxt;
    idx_r <= idx_nxt; pois_r <= pois_nxt; size_r <= size_nxt; span_r <= span_nxt;
  end

  assign out_access_ok = ok_r;
  assign out_status = st_r;
  assign out_store_op = (typ_r == sbac_pkg::REQ_STORE);
  assign out_fault_address = addr_r;
  assign out_fault_size = size_r;
endmodule

// ===== sv/sbac_checker.sv =====
`include "shadow_bitmap_access_checker_macros.svh"
module sbac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_access_ok,
  input logic [1:0]  out_status,
  input logic        pready
);
  `SBAC_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
  `SBAC_ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid && !busy)
  `SBAC_ASSERT_IMPL(a_valid_busy, clk, rst_n, out_valid, busy)
  `SBAC_ASSERT_IMPL(a_fail_done, clk, rst_n, out_valid && !out_access_ok,
    out_status == sbac_pkg::ST_DONE)
  `SBAC_ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, pready)
endmodule

bind shadow_bitmap_access_checker sbac_checker u_sbac_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_access_ok(out_access_ok), .out_status(out_status), .pready(pready));

// ===== sim/shadow_bitmap_access_checker_test.sv =====
`timescale 1ns / 100ps

module shadow_bitmap_access_checker_test;

  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int RANDOM_REQUESTS = 1750;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [31:0] WIN_BASE = 32'h2000_0000;

  typedef struct packed {
    logic        access_ok;
    logic [1:0]  status;
    logic        store_op;
    logic [31:0] fault_address;
    logic [16:0] fault_size;
  } access_result_t;

  typedef struct {
    logic [2:0]        kind;
    logic [31:0]       addr;
    logic [16:0]       len;
    bit                typed;
    logic              ok;
    sbac_pkg::status_t st;
  } stim_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_address = '0;
  logic [16:0] in_region_size = '0;
  logic        out_valid;
  logic        out_access_ok;
  logic [1:0]  out_status;
  logic        out_store_op;
  logic [31:0] out_fault_address;
  logic [16:0] out_fault_size;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow state mirrored by the predictor
  logic [7:0]  shadow_mem [sbac_pkg::SHADOW_BYTES];
  logic [31:0] slot_addr [sbac_pkg::ALLOC_SLOTS];
  logic [16:0] slot_len [sbac_pkg::ALLOC_SLOTS];
  logic        cur_enable;
  logic [31:0] cur_base;
  logic [31:0] cur_end;

  access_result_t pending_results[$];
  logic [31:0]    live_allocs[$];
  int errors = 0;
  int requests = 0;
  int results = 0;
  int cycles = 0;
  bit steady = 0;

  shadow_bitmap_access_checker i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit span_in_window(input logic [31:0] a, input logic [16:0] len,
                                        output longint unsigned rel);
    longint unsigned s, e;
    s = a;
    e = s + len;
    rel = 0;
    if (len > sbac_pkg::SIZE_LIMIT) return 0;
    if (s < cur_base || e > {32'd0, cur_end}) return 0;
    rel = s - cur_base;
    if (len == 0) return 1;
    return ((rel + len - 1) >> 3) < sbac_pkg::SHADOW_BYTES;
  endfunction

  // mode 0 tests, 1 sets, 2 clears; returns 1 when no covered bit was set
  function automatic bit walk_span(input longint unsigned rel, input logic [16:0] len,
                                   input int mode);
    longint unsigned first, last, i;
    int lo, hi;
    logic [7:0] m;
    bit clean;
    clean = 1;
    first = rel >> 3;
    last = (rel + len - 1) >> 3;
    for (i = first; i <= last; i++) begin
      lo = (i == first) ? int'(rel & 7) : 0;
      hi = (i == last) ? int'((rel + len - 1) & 7) : 7;
      m = 8'(((255 >> (7 - (hi - lo))) << lo) & 255);
      case (mode)
        0: if ((shadow_mem[i] & m) != 0) clean = 0;
        1: shadow_mem[i] = shadow_mem[i] | m;
        default: shadow_mem[i] = shadow_mem[i] & ~m;
      endcase
    end
    return clean;
  endfunction

  function automatic sbac_pkg::status_t mark_region(input logic [31:0] a,
                                                    input logic [16:0] len,
                                                    input bit poison);
    longint unsigned rel;
    if (!span_in_window(a, len, rel)) return sbac_pkg::ST_UNMON;
    if (len != 0) void'(walk_span(rel, len, poison ? 1 : 2));
    return sbac_pkg::ST_DONE;
  endfunction

  function automatic access_result_t predict_access(input logic [2:0] kind,
                                                    input logic [31:0] a,
                                                    input logic [16:0] len);
    access_result_t r;
    longint unsigned rel;
    int k;
    r = '{access_ok: 1'b1, status: sbac_pkg::ST_DONE, store_op: 1'b0, fault_address: a,
          fault_size: len};
    case (kind)
      sbac_pkg::REQ_LOAD, sbac_pkg::REQ_STORE: begin
        r.store_op = (kind == sbac_pkg::REQ_STORE);
        if (cur_enable) begin
          if (!span_in_window(a, len, rel)) r.status = sbac_pkg::ST_UNMON;
          else if (len != 0 && !walk_span(rel, len, 0)) r.access_ok = 1'b0;
        end
      end
      sbac_pkg::REQ_UNPOISON, sbac_pkg::REQ_POISON:
        r.status = mark_region(a, len, kind == sbac_pkg::REQ_POISON);
      sbac_pkg::REQ_ALLOC: if (a != 0) begin
        for (k = 0; k < sbac_pkg::ALLOC_SLOTS && slot_addr[k] != 0; k++) ;
        if (k >= sbac_pkg::ALLOC_SLOTS) r.status = sbac_pkg::ST_FULL;
        else begin
          r.status = mark_region(a, len, 0);
          slot_addr[k] = a;
          slot_len[k] = len;
        end
      end
      sbac_pkg::REQ_FREE: if (a != 0) begin
        for (k = 0; k < sbac_pkg::ALLOC_SLOTS && slot_addr[k] != a; k++) ;
        if (k >= sbac_pkg::ALLOC_SLOTS) r.status = sbac_pkg::ST_NOTFOUND;
        else begin
          r.status = mark_region(a, slot_len[k], 1);
          slot_addr[k] = 0;
          slot_len[k] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid) begin
      results++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending, address %h", out_fault_address);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_access_ok !== want.access_ok) begin
          $error("access_ok: expected %0d, got %0d", want.access_ok, out_access_ok);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_store_op !== want.store_op) begin
          $error("store_op: expected %0d, got %0d", want.store_op, out_store_op);
          errors++;
        end
        if (out_fault_address !== want.fault_address) begin
          $error("fault_address: expected %h, got %h", want.fault_address,
                 out_fault_address);
          errors++;
        end
        if (out_fault_size !== want.fault_size) begin
          $error("fault_size: expected %0d, got %0d", want.fault_size, out_fault_size);
          errors++;
        end
      end
    end
  end

  // called right after a rising edge; returns at the edge that took the request
  task automatic issue(input logic [2:0] kind, input logic [31:0] a,
                       input logic [16:0] len, input bit typed = 0,
                       input logic ok = 1,
                       input sbac_pkg::status_t st = sbac_pkg::ST_DONE);
    access_result_t r;
    if (!steady && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_address <= a;
    in_region_size <= len;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    r = predict_access(kind, a, len);
    if (typed) begin
      r.access_ok = ok;
      r.status = st;
    end
    pending_results.push_back(r);
    requests++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input sbac_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      sbac_pkg::REG_ENABLE: cur_enable = val[0];
      sbac_pkg::REG_BASE: cur_base = val;
      default: cur_end = val;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic en, input logic [31:0] b, input logic [31:0] e);
    reg_write(sbac_pkg::REG_ENABLE, {31'd0, en});
    reg_write(sbac_pkg::REG_BASE, b);
    reg_write(sbac_pkg::REG_END, e);
  endtask

  function automatic logic [31:0] pick_addr();
    logic [31:0] span;
    int r;
    r = $urandom_range(99);
    span = cur_end - cur_base;
    if (cur_end <= cur_base || span > 32'h10000) span = 32'h10000;
    if (r < 8) return $urandom;
    if (r < 16) return cur_base + span - $urandom_range(0, 16);
    if (r < 20) return cur_base - $urandom_range(1, 8);
    return cur_base + $urandom_range(0, span);
  endfunction

  function automatic logic [16:0] pick_len();
    int r;
    r = $urandom_range(999);
    if (r < 700) return 17'($urandom_range(0, 16));
    if (r < 900) return 17'($urandom_range(0, 256));
    if (r < 985) return 17'($urandom_range(0, 4096));
    if (r < 990) return sbac_pkg::SIZE_LIMIT;
    return 17'($urandom_range(sbac_pkg::SIZE_LIMIT + 1, 17'h1FFFF));
  endfunction

  task automatic random_burst(input int count);
    int r, j;
    logic [31:0] a;
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) steady = 1;
      if (n == count / 3 + 120) steady = 0;
      r = $urandom_range(99);
      a = pick_addr();
      if (r < 25) issue(sbac_pkg::REQ_LOAD, a, pick_len());
      else if (r < 45) issue(sbac_pkg::REQ_STORE, a, pick_len());
      else if (r < 60) begin
        issue(sbac_pkg::REQ_ALLOC, a, pick_len());
        live_allocs.push_back(a);
      end else if (r < 75) begin
        if (live_allocs.size() != 0 && $urandom_range(99) < 80) begin
          j = $urandom_range(live_allocs.size() - 1);
          a = live_allocs[j];
          live_allocs.delete(j);
        end
        issue(sbac_pkg::REQ_FREE, a, 17'($urandom));
      end else if (r < 85) issue(sbac_pkg::REQ_POISON, a, pick_len());
      else if (r < 95) issue(sbac_pkg::REQ_UNPOISON, a, pick_len());
      else issue(3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI)), $urandom,
                 17'($urandom));
    end
    steady = 0;
  endtask

  initial begin
    stim_row_t rows[$];
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    foreach (slot_addr[i]) begin
      slot_addr[i] = '0;
      slot_len[i] = '0;
    end
    cur_enable = 0;
    cur_base = '0;
    cur_end = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // checker off after reset: everything passes
    issue(sbac_pkg::REQ_LOAD, 32'hFFFF_FFFF, sbac_pkg::SIZE_LIMIT, 1, 1, sbac_pkg::ST_DONE);
    issue(sbac_pkg::REQ_STORE, 32'h0, 17'd0, 1, 1, sbac_pkg::ST_DONE);
    drain();
    set_window(1, WIN_BASE, WIN_BASE + 32'h10000);

    rows = '{
      '{sbac_pkg::REQ_LOAD,     WIN_BASE,       17'd1,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_POISON,   WIN_BASE,       17'd16,    1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE + 15,  17'd1,     1, 0, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE + 16,  17'd4,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_UNPOISON, WIN_BASE + 3,   17'd2,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE + 2,   17'd3,     0, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE - 1,   17'd1,     1, 1, sbac_pkg::ST_UNMON},
      '{sbac_pkg::REQ_STORE,    WIN_BASE + 32'hFFFF, 17'd1, 0, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_STORE,    WIN_BASE + 32'hFFFF, 17'd2, 1, 1, sbac_pkg::ST_UNMON},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE, sbac_pkg::SIZE_LIMIT, 1, 0, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE,       17'h1FFFF, 1, 1, sbac_pkg::ST_UNMON},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE + 5,   17'd0,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_ALLOC,    32'h0,          17'd8,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_FREE,     32'h0,          17'd0,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_FREE,     WIN_BASE + 100, 17'd0,     1, 1, sbac_pkg::ST_NOTFOUND},
      '{sbac_pkg::REQ_ALLOC,    WIN_BASE + 64,  17'd32,    1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_FREE,     WIN_BASE + 64,  17'd0,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_LOAD,     WIN_BASE + 64,  17'd32,    1, 0, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_ALLOC,    WIN_BASE + 200, 17'd8,     0, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_ALLOC,    WIN_BASE + 200, 17'd24,    0, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_FREE,     WIN_BASE + 200, 17'd0,     0, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_ALLOC,    32'hFFFF_FFF0,  17'd16,    1, 1, sbac_pkg::ST_UNMON},
      '{sbac_pkg::REQ_FREE,     32'hFFFF_FFF0,  17'd0,     1, 1, sbac_pkg::ST_UNMON},
      '{REQ_UNKNOWN_LO,         32'hFFFF_FFFF,  17'h1FFFF, 1, 1, sbac_pkg::ST_DONE},
      '{REQ_UNKNOWN_HI,         WIN_BASE,       17'd4,     1, 1, sbac_pkg::ST_DONE},
      '{sbac_pkg::REQ_UNPOISON, WIN_BASE, sbac_pkg::SIZE_LIMIT, 1, 1, sbac_pkg::ST_DONE}
    };
    foreach (rows[i])
      issue(rows[i].kind, rows[i].addr, rows[i].len, rows[i].typed, rows[i].ok, rows[i].st);

    // random phases over a spread of window settings
    random_burst(RANDOM_REQUESTS / 6);
    drain();
    set_window(1, 32'h0, 32'hFFFF_FFFF);
    random_burst(RANDOM_REQUESTS / 6);
    drain();
    set_window(0, WIN_BASE, WIN_BASE + 32'h10000);
    random_burst(RANDOM_REQUESTS / 6);
    drain();
    set_window(1, 32'hFFFF_0000, 32'hFFFF_FFFF);
    random_burst(RANDOM_REQUESTS / 6);
    drain();
    set_window(1, WIN_BASE + 32'h1000, WIN_BASE + 32'h1100);
    random_burst(RANDOM_REQUESTS / 6);
    drain();
    set_window(1, WIN_BASE, WIN_BASE - 1);
    random_burst(RANDOM_REQUESTS / 12);
    drain();
    set_window(1, WIN_BASE, WIN_BASE + 32'h10000);
    random_burst(RANDOM_REQUESTS / 12);
    drain();
    repeat (20) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("Ran %0d requests (%0d results) across seven window settings,", requests, results);
    $display("including poison/unpoison, alloc/free slot table and unmonitored spans.");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ===== shadow_bitmap_access_checker.f =====
+incdir+sv
sv/sbac_pkg.sv
sv/sbac_ram.sv
sv/shadow_bitmap_access_checker.sv
sv/sbac_checker.sv
sim/shadow_bitmap_access_checker_test.sv
